// ----- sv/fcafm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcafm_pkg
// shared types and constants of the four-channel actuator fault monitor
// ----------------------------------------------------------------------------
package fcafm_pkg;

  localparam int THRESH_BITS    = 16;
  localparam int SENSE_BITS     = 4;
  localparam int CMD_BITS       = 8;
  localparam int RAISE_BASE     = 4;
  localparam int RUN_BIT        = 7;
  localparam int OUT_BITS       = 4;
  localparam int IN_DATA_BITS   = 32;
  localparam int OUT_DATA_BITS  = 8;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd1000;

  // input field positions inside s_tdata
  localparam int CMD_VALID_LSB  = 0;
  localparam int CMD_ENABLE_LSB = 1;
  localparam int CMD_POSE_LSB   = 9;
  localparam int TRIP_LSB       = 17;
  localparam int OFF_FAULT_LSB  = 21;
  localparam int ON_FAULT_LSB   = 25;

  // per-channel view of one poll transaction
  typedef struct packed {
    logic cmd_valid;
    logic run;
    logic enable_req;
    logic lower_req;
    logic raise_req;
    logic trip;
    logic off_fault;
    logic on_fault;
  } chan_ctl_t;

endpackage : fcafm_pkg
`default_nettype wire

// ----- sv/fcafm_channel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcafm_channel
// one channel: command holds, drive latch and saturating stuck counter
// ----------------------------------------------------------------------------
module fcafm_channel
  import fcafm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire chan_ctl_t              ctl,
  input  wire logic [THRESH_BITS-1:0] threshold,
  output logic                        drive_next,
  output logic                        error_next
);

  localparam int CMP_BITS = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  rearmed;
  logic                  raise_hold;
  logic                  lower_hold;
  logic                  drive;
  logic [COUNT_BITS-1:0] stuck_count;

  logic                  rearmed_next;
  logic                  raise_hold_next;
  logic                  lower_hold_next;
  logic [COUNT_BITS-1:0] stuck_count_next;
  logic                  pending;
  logic                  drive_set;
  logic                  fault;
  logic [COUNT_BITS-1:0] count_base;

  always_comb begin
    rearmed_next     = rearmed;
    raise_hold_next  = raise_hold;
    lower_hold_next  = lower_hold;
    pending          = 1'b0;
    if (ctl.cmd_valid) begin
      rearmed_next    = !ctl.enable_req;
      pending         = ctl.enable_req && rearmed;
      lower_hold_next = ctl.lower_req;
      raise_hold_next = !ctl.lower_req && ctl.raise_req;
    end
    drive_set  = drive || pending || raise_hold_next;
    drive_next = drive_set && ctl.trip && !lower_hold_next;
    fault      = drive_next ? ctl.on_fault : ctl.off_fault;
    count_base = (drive != drive_next) ? '0 : stuck_count;
    if (!fault) begin
      stuck_count_next = '0;
    end else if (count_base == COUNT_MAX) begin
      stuck_count_next = count_base;
    end else begin
      stuck_count_next = count_base + 1'b1;
    end
    error_next = CMP_BITS'(stuck_count_next) >= CMP_BITS'(threshold);
    if (!ctl.run) begin
      rearmed_next     = 1'b1;
      raise_hold_next  = 1'b0;
      lower_hold_next  = 1'b0;
      drive_next       = 1'b0;
      stuck_count_next = '0;
      error_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rearmed     <= 1'b1;
      raise_hold  <= 1'b0;
      lower_hold  <= 1'b0;
      drive       <= 1'b0;
      stuck_count <= '0;
    end else if (step) begin
      rearmed     <= rearmed_next;
      raise_hold  <= raise_hold_next;
      lower_hold  <= lower_hold_next;
      drive       <= drive_next;
      stuck_count <= stuck_count_next;
    end
  end

endmodule : fcafm_channel
`default_nettype wire

// ----- sv/four_channel_actuator_fault_monitor_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_actuator_fault_monitor_top
// per-channel actuator drive latch with stuck-sensor error flags
// ----------------------------------------------------------------------------
// Each input transaction is one poll pass (optional command plus sensor
// nibbles) and yields exactly one output transaction with the drive and error
// flags after that pass. The pass is evaluated combinationally from the
// channel state registers into the output register, so one transaction is
// taken per clock; the input is stalled only while the output register holds
// a result that the sink has not taken. The threshold register may be
// written at any time the block is idle.
module four_channel_actuator_fault_monitor_top
  import fcafm_pkg::*;
#(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wen,
  input  wire logic [THRESH_BITS-1:0]   cfg_wdata,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // cmd_valid, cmd_enable, cmd_pose, trip_sense, off_fault_sense, on_fault_sense
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // drive_flags, error_flags
  output logic [OUT_DATA_BITS-1:0]      m_tdata
);

  logic                   cmd_valid;
  logic [CMD_BITS-1:0]    cmd_enable;
  logic [CMD_BITS-1:0]    cmd_pose;
  logic [SENSE_BITS-1:0]  trip_sense;
  logic [SENSE_BITS-1:0]  off_fault_sense;
  logic [SENSE_BITS-1:0]  on_fault_sense;

  logic                   run_mode;
  logic                   run_next;
  logic [THRESH_BITS-1:0] threshold;
  logic                   step;
  logic [CHANNELS-1:0]    drive_vec;
  logic [CHANNELS-1:0]    error_vec;
  logic [OUT_BITS-1:0]    drive_flags;
  logic [OUT_BITS-1:0]    error_flags;

  assign cmd_valid       = s_tdata[CMD_VALID_LSB];
  assign cmd_enable      = s_tdata[CMD_ENABLE_LSB +: CMD_BITS];
  assign cmd_pose        = s_tdata[CMD_POSE_LSB +: CMD_BITS];
  assign trip_sense      = s_tdata[TRIP_LSB +: SENSE_BITS];
  assign off_fault_sense = s_tdata[OFF_FAULT_LSB +: SENSE_BITS];
  assign on_fault_sense  = s_tdata[ON_FAULT_LSB +: SENSE_BITS];

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;
  assign run_next = cmd_valid ? cmd_enable[RUN_BIT] : run_mode;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    chan_ctl_t ctl;

    assign ctl.cmd_valid  = cmd_valid;
    assign ctl.run        = run_next;
    assign ctl.enable_req = cmd_enable[i];
    assign ctl.lower_req  = cmd_pose[i];
    if (RAISE_BASE + i < CMD_BITS) begin : g_raise
      assign ctl.raise_req = cmd_pose[RAISE_BASE + i];
    end else begin : g_no_raise
      assign ctl.raise_req = 1'b0;
    end
    if (i < SENSE_BITS) begin : g_sense
      assign ctl.trip      = trip_sense[i];
      assign ctl.off_fault = off_fault_sense[i];
      assign ctl.on_fault  = on_fault_sense[i];
    end else begin : g_no_sense
      assign ctl.trip      = 1'b0;
      assign ctl.off_fault = 1'b0;
      assign ctl.on_fault  = 1'b0;
    end

    fcafm_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_chan (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .ctl       (ctl),
      .threshold (threshold),
      .drive_next(drive_vec[i]),
      .error_next(error_vec[i])
    );
  end

  for (genvar b = 0; b < OUT_BITS; b++) begin : g_out
    if (b < CHANNELS) begin : g_bit
      assign drive_flags[b] = drive_vec[b];
      assign error_flags[b] = error_vec[b];
    end else begin : g_pad
      assign drive_flags[b] = 1'b0;
      assign error_flags[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wen) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (step) begin
        run_mode <= run_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {error_flags, drive_flags};
    end
  end

endmodule : four_channel_actuator_fault_monitor_top
`default_nettype wire
